/* rtl/core/dfwd_pkg.sv */
// ---------------------------------------------------------------------------
// Darcy flux package
// Shared beat types, fixed-point constants and pipeline stage positions.
// ---------------------------------------------------------------------------
package dfwd_pkg;

  // Input beat: one quadrature point.
  typedef struct packed {
    logic [24:0]        temperature;
    logic signed [39:0] grad_p_x;
    logic signed [39:0] grad_p_y;
    logic signed [39:0] grad_p_z;
    logic               last_point;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [25:0]        density;
    logic [47:0]        mobility;
    logic signed [47:0] flux_x;
    logic signed [47:0] flux_y;
    logic signed [47:0] flux_z;
    logic signed [47:0] velocity_x;
    logic signed [47:0] velocity_y;
    logic signed [47:0] velocity_z;
    logic               saturated;
    logic               last_point_out;
  } out_beat_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PERM = 3'd0;
  localparam logic [2:0] CFG_VISC = 3'd1;
  localparam logic [2:0] CFG_PORO = 3'd2;
  localparam logic [2:0] CFG_GACC = 3'd3;
  localparam logic [2:0] CFG_GDX  = 3'd4;
  localparam logic [2:0] CFG_GDY  = 3'd5;
  localparam logic [2:0] CFG_GDZ  = 3'd6;

  // Density formula constants in the Q9.16 temperature scale.
  localparam logic [25:0] C_T0    = 26'd261246;
  localparam logic [25:0] C_NUM   = 26'd18936064;
  localparam logic [25:0] C_DEN   = 26'd4464943;

  // The fraction divisor 5089292 is four times C_FDIV. The quotient by
  // C_FDIV comes from a reciprocal multiply, exact for numerators below
  // 2^53; C_FBIG is the smallest numerator whose quotient exceeds 2^32.
  localparam logic [20:0] C_FDIV  = 21'd1272323;
  localparam logic [53:0] C_RCP   =
    54'(((128'd1 << 74) + 128'(C_FDIV) - 128'd1) / 128'(C_FDIV));
  localparam logic [52:0] C_FBIG  =
    53'(((128'd1 << 32) + 128'd1) * 128'(C_FDIV));

  // Saturation limits of a 48-bit signed magnitude.
  localparam logic [48:0] LIM_POS = 49'h0_7FFF_FFFF_FFFF;
  localparam logic [48:0] LIM_NEG = 49'h0_8000_0000_0000;

  // Divider depths (one quotient bit per stage); LAT_F is the depth of
  // the reciprocal multiply for the density fraction.
  localparam int LAT_R = 19;
  localparam int LAT_F = 4;
  localparam int LAT_M = 42;
  localparam int LAT_Q = 49;
  localparam int LAT_V = 48;

  // Register stage positions, counted from the input register (stage 0).
  localparam int S_D1  = 1;
  localparam int S_R   = S_D1 + LAT_R;
  localparam int S_P   = S_R + 1;
  localparam int S_P10 = S_P + 1;
  localparam int S_F   = S_P10 + LAT_F;
  localparam int S_RHO = S_F + 1;
  localparam int S_KR  = S_RHO + 1;
  localparam int S_MOB = S_KR + LAT_M;
  localparam int S_BG  = S_KR + 1;
  localparam int S_S   = S_BG + 1;
  localparam int S_M   = S_S + 1;
  localparam int S_PK  = S_M + 1;
  localparam int S_N   = S_PK + 1;
  localparam int S_NQ  = S_N + 1;
  localparam int S_Q   = S_NQ + LAT_Q;
  localparam int S_FLX = S_Q + 1;
  localparam int S_NV  = S_FLX + 1;
  localparam int S_V   = S_NV + LAT_V;
  localparam int S_OUT = S_V + 1;

endpackage

/* rtl/core/dfwd_dly.sv */
// ---------------------------------------------------------------------------
// Delay line
// Shifts a word through N registers under a common advance enable.
// ---------------------------------------------------------------------------
module dfwd_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  // Shift on every advance.
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

/* rtl/core/dfwd_div.sv */
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; caller guarantees num < den * 2^QW.
// ---------------------------------------------------------------------------
module dfwd_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stg
    localparam int BIT = QW - 1 - j;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_nxt;
    logic [CW-1:0] sh_w;
    logic [CW-1:0] diff_w;
    logic          ge_w;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    // Trial subtract of the shifted divisor.
    always_comb begin
      sh_w        = CW'(den_in) << BIT;
      ge_w        = CW'(rem_in) >= sh_w;
      diff_w      = CW'(rem_in) - sh_w;
      q_nxt       = q_in;
      q_nxt[BIT]  = ge_w;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= q_nxt;
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge_w ? diff_w[NW-1:0] : rem_in;
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

/* rtl/core/dfwd_dens.sv */
// ---------------------------------------------------------------------------
// Water density pipeline
// Rational density formula in fixed point, from temperature to Q10.16 rho.
// ---------------------------------------------------------------------------
module dfwd_dens (
  input  logic        clk,
  input  logic        en,
  input  logic [24:0] temp,
  output logic [25:0] rho,
  output logic        rho_flag
);

  import dfwd_pkg::*;

  logic signed [25:0] d_r;
  logic [41:0]        numr_r;
  logic [25:0]        denr_r;
  logic signed [51:0] dd_w;
  logic [33:0]        ddh_r;
  logic [33:0]        ddh_d;
  logic [18:0]        r_w;
  logic [52:0]        p_r;
  logic [56:0]        p10_r;
  logic [52:0]        fn_r;
  logic               fbig1_r;
  logic [53:0]        ppll_r;
  logic [53:0]        pplh_r;
  logic [52:0]        pphl_r;
  logic [52:0]        pphh_r;
  logic               fbig2_r;
  logic [55:0]        fmid_r;
  logic [52:0]        fhh_r;
  logic               fbig3_r;
  logic [79:0]        fsum_w;
  logic [32:0]        f_r;
  logic               fbig4_r;
  logic               neg_w;
  logic [32:0]        x_w;
  logic [41:0]        rp_w;
  logic [25:0]        rho_r;
  logic               flag_r;

  // Offset temperature and ratio operands.
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= $signed({1'b0, temp}) - $signed(C_T0);
      numr_r <= {26'(temp) + C_NUM, 16'd0};
      denr_r <= 26'(temp) + C_DEN;
    end
  end

  // Ratio (T+288.9)/(T+68.1) in Q.16.
  dfwd_div #(.NW(42), .DW(26), .QW(LAT_R)) u_div_r (
    .clk (clk),
    .en  (en),
    .num (numr_r),
    .den (denr_r),
    .q   (r_w)
  );

  // Squared offset, aligned with the ratio.
  assign dd_w = d_r * d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ddh_r <= dd_w[49:16];
    end
  end

  dfwd_dly #(.W(34), .N(S_R - S_D1 - 1)) u_dly_dd (
    .clk (clk),
    .en  (en),
    .d   (ddh_r),
    .q   (ddh_d)
  );

  // Product and times ten.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= 53'(ddh_d) * 53'(r_w);
      p10_r <= {p_r, 3'd0} + {2'd0, p_r, 1'b0};
    end
  end

  // Fraction: quarter of the numerator, then the reciprocal multiply.
  // Numerators at or above C_FBIG give a fraction above one and clamp.
  always_ff @(posedge clk) begin
    if (en) begin
      fbig1_r <= p10_r[56:2] >= 55'(C_FBIG);
      fn_r    <= p10_r[54:2];
    end
  end

  // Four partial products of about 27 by 27 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      ppll_r  <= 54'(fn_r[26:0]) * 54'(C_RCP[26:0]);
      pplh_r  <= 54'(fn_r[26:0]) * 54'(C_RCP[53:27]);
      pphl_r  <= 53'(fn_r[52:27]) * 53'(C_RCP[26:0]);
      pphh_r  <= 53'(fn_r[52:27]) * 53'(C_RCP[53:27]);
      fbig2_r <= fbig1_r;
    end
  end

  // Middle terms first, then the high term; the product is kept from bit 27.
  always_ff @(posedge clk) begin
    if (en) begin
      fmid_r  <= 56'(pplh_r) + 56'(pphl_r) + 56'(ppll_r[53:27]);
      fhh_r   <= pphh_r;
      fbig3_r <= fbig2_r;
    end
  end

  assign fsum_w = {fhh_r, 27'd0} + 80'(fmid_r);

  always_ff @(posedge clk) begin
    if (en) begin
      f_r     <= fsum_w[79:47];
      fbig4_r <= fbig3_r;
    end
  end

  // Density, clamped at zero.
  always_comb begin
    neg_w = fbig4_r;
    x_w   = 33'(34'h1_0000_0000 - 34'(f_r));
    rp_w  = 42'(x_w) * 42'd1000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rho_r  <= neg_w ? '0 : rp_w[41:16];
      flag_r <= neg_w;
    end
  end

  assign rho      = rho_r;
  assign rho_flag = flag_r;

endmodule

/* rtl/core/dfwd_lane.sv */
// ---------------------------------------------------------------------------
// Flux and velocity lane
// One axis: body force, scaled quotient by viscosity, division by porosity.
// ---------------------------------------------------------------------------
module dfwd_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [33:0]        b,
  input  logic signed [39:0] gp,
  input  logic signed [15:0] gdir,
  input  logic [31:0]        k,
  input  logic [19:0]        mu,
  input  logic [15:0]        phi,
  output logic signed [47:0] flux,
  output logic signed [47:0] vel,
  output logic               flag
);

  import dfwd_pkg::*;

  logic signed [39:0] gp_r;
  logic signed [50:0] bg_r;
  logic signed [62:0] s_r;
  logic [62:0]        abs_w;
  logic [61:0]        m_r;
  logic               neg_r;
  logic [63:0]        pk0_r;
  logic [61:0]        pk1_r;
  logic [93:0]        km_w;
  logic [63:0]        n_r;
  logic               ovf_w;
  logic               ovf_r;
  logic [63:0]        numq_r;
  logic [48:0]        q_w;
  logic               neg_q;
  logic               ovf_q;
  logic [48:0]        limf_w;
  logic               satf_w;
  logic [47:0]        fm_w;
  logic [47:0]        fm_r;
  logic signed [47:0] flux_r;
  logic               fflag_r;
  logic               negf_r;
  logic               fz_r;
  logic               vovf_r;
  logic               negv_r;
  logic [63:0]        numv_r;
  logic [47:0]        qv_w;
  logic [2:0]         vctl_d;
  logic [48:0]        fx_d;
  logic [48:0]        limv_w;
  logic               satv_w;
  logic [47:0]        vm_w;
  logic signed [47:0] vel_r;
  logic               vflag_r;

  // Body force term and signed sum in Q30.
  always_ff @(posedge clk) begin
    if (en) begin
      gp_r  <= gp;
      bg_r  <= $signed({1'b0, b}) * gdir;
      s_r   <= 63'($signed({gp_r, 22'd0})) + 63'(bg_r);
    end
  end

  // Magnitude and flux sign (opposite to the sum).
  assign abs_w = s_r[62] ? 63'(-s_r) : 63'(s_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r   <= abs_w[61:0];
      neg_r <= !s_r[62] && (s_r != '0);
    end
  end

  // Permeability product split in two partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pk0_r <= 64'(k) * 64'(m_r[31:0]);
      pk1_r <= 62'(k) * 62'(m_r[61:32]);
    end
  end

  assign km_w = 94'(pk0_r) + {pk1_r, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= km_w[93:30];
    end
  end

  // Quotients of 2^49 and above saturate anyway; skip their division.
  assign ovf_w = {5'd0, n_r[63:49]} >= mu;

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r  <= ovf_w;
      numq_r <= ovf_w ? '0 : n_r;
    end
  end

  dfwd_div #(.NW(64), .DW(20), .QW(LAT_Q)) u_div_q (
    .clk (clk),
    .en  (en),
    .num (numq_r),
    .den (mu),
    .q   (q_w)
  );

  dfwd_dly #(.W(1), .N(S_Q - S_M)) u_dly_neg (
    .clk (clk),
    .en  (en),
    .d   (neg_r),
    .q   (neg_q)
  );

  dfwd_dly #(.W(1), .N(LAT_Q)) u_dly_ovf (
    .clk (clk),
    .en  (en),
    .d   (ovf_r),
    .q   (ovf_q)
  );

  // Flux magnitude clamp and sign.
  always_comb begin
    limf_w = neg_q ? LIM_NEG : LIM_POS;
    satf_w = ovf_q || (q_w > limf_w);
    fm_w   = satf_w ? limf_w[47:0] : q_w[47:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fm_r    <= fm_w;
      flux_r  <= neg_q ? $signed(48'd0 - fm_w) : $signed(fm_w);
      fflag_r <= satf_w;
      negf_r  <= neg_q;
    end
  end

  // Velocity operands; zero porosity falls into the overflow case.
  always_ff @(posedge clk) begin
    if (en) begin
      fz_r   <= fm_r == '0;
      vovf_r <= (fm_r != '0) && (fm_r[47:32] >= phi);
      negv_r <= negf_r;
      numv_r <= ((fm_r != '0) && (fm_r[47:32] >= phi)) ? '0 : {fm_r, 16'd0};
    end
  end

  dfwd_div #(.NW(64), .DW(16), .QW(LAT_V)) u_div_v (
    .clk (clk),
    .en  (en),
    .num (numv_r),
    .den (phi),
    .q   (qv_w)
  );

  dfwd_dly #(.W(3), .N(LAT_V)) u_dly_vctl (
    .clk (clk),
    .en  (en),
    .d   ({negv_r, fz_r, vovf_r}),
    .q   (vctl_d)
  );

  dfwd_dly #(.W(49), .N(S_OUT - S_FLX)) u_dly_flux (
    .clk (clk),
    .en  (en),
    .d   ({fflag_r, flux_r}),
    .q   (fx_d)
  );

  // Velocity clamp and sign.
  always_comb begin
    limv_w = vctl_d[2] ? LIM_NEG : LIM_POS;
    satv_w = !vctl_d[1] && (vctl_d[0] || (49'(qv_w) > limv_w));
    if (vctl_d[1]) begin
      vm_w = '0;
    end else if (satv_w) begin
      vm_w = limv_w[47:0];
    end else begin
      vm_w = qv_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_r   <= vctl_d[2] ? $signed(48'd0 - vm_w) : $signed(vm_w);
      vflag_r <= satv_w;
    end
  end

  assign flux = $signed(fx_d[47:0]);
  assign vel  = vel_r;
  assign flag = fx_d[48] | vflag_r;

endmodule

/* rtl/core/darcy_flux_with_water_density.sv */
// ---------------------------------------------------------------------------
// Darcy flux with water density
// Per quadrature point: empirical water density, mobility k*rho/mu, Darcy
// flux -(k/mu)*(gradP + rho*g*gdir) and pore velocity flux/porosity.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    dfwd_pkg::in_beat_t
//   out_     output     valid / stall    dfwd_pkg::out_beat_t
//   cfg_     input      valid / ready    3-bit index, 32-bit data
//
// One beat enters per cycle while the output beat is not stalled. Depth is
// set by the bit-per-stage dividers for the temperature ratio and, on each
// lane, the viscosity and porosity quotients. The whole pipeline advances
// together and holds when the output beat is stalled; in_stall follows that
// hold. Reset only clears the valid bits and loads the register defaults;
// cfg_ready stays high.
// ---------------------------------------------------------------------------
module darcy_flux_with_water_density (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dfwd_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dfwd_pkg::out_beat_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  import dfwd_pkg::*;

  logic [31:0]        perm_r;
  logic [19:0]        visc_r;
  logic [15:0]        poro_r;
  logic [23:0]        gacc_r;
  logic signed [15:0] gdx_r;
  logic signed [15:0] gdy_r;
  logic signed [15:0] gdz_r;
  logic [19:0]        mu_w;

  logic               en;
  logic [S_OUT:0]     vld_r;
  in_beat_t           in_r;

  logic [25:0]        rho_w;
  logic               rflag_w;
  logic [57:0]        kr_r;
  logic [49:0]        bp_w;
  logic [33:0]        b_r;
  logic [41:0]        mob_w;
  logic [41:0]        mob_d;
  logic [26:0]        rho_d;
  logic               last_d;
  logic [119:0]       gp_d;

  logic signed [47:0] fx_w, fy_w, fz_w;
  logic signed [47:0] vx_w, vy_w, vz_w;
  logic               lfx_w, lfy_w, lfz_w;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_r <= 32'd1000000;
      visc_r <= 20'd1000;
      poro_r <= 16'd6554;
      gacc_r <= 24'd642690;
      gdx_r  <= '0;
      gdy_r  <= '0;
      gdz_r  <= 16'sd16384;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERM: perm_r <= cfg_data;
        CFG_VISC: visc_r <= cfg_data[19:0];
        CFG_PORO: poro_r <= cfg_data[15:0];
        CFG_GACC: gacc_r <= cfg_data[23:0];
        CFG_GDX:  gdx_r  <= $signed(cfg_data[15:0]);
        CFG_GDY:  gdy_r  <= $signed(cfg_data[15:0]);
        CFG_GDZ:  gdz_r  <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign mu_w      = (visc_r == '0) ? 20'd1 : visc_r;

  // Pipeline advance: everything moves unless the output beat is held.
  assign en       = !(vld_r[S_OUT] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[S_OUT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
    end
  end

  // Density.
  dfwd_dens u_dens (
    .clk      (clk),
    .en       (en),
    .temp     (in_r.temperature),
    .rho      (rho_w),
    .rho_flag (rflag_w)
  );

  // Mobility product and body force magnitude rho*g.
  assign bp_w = 50'(rho_w) * 50'(gacc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      kr_r <= 58'(perm_r) * 58'(rho_w);
      b_r  <= bp_w[49:16];
    end
  end

  dfwd_div #(.NW(42), .DW(20), .QW(LAT_M)) u_div_m (
    .clk (clk),
    .en  (en),
    .num (kr_r[57:16]),
    .den (mu_w),
    .q   (mob_w)
  );

  // Side data aligned to the output stage.
  dfwd_dly #(.W(42), .N(S_OUT - S_MOB)) u_dly_mob (
    .clk (clk),
    .en  (en),
    .d   (mob_w),
    .q   (mob_d)
  );

  dfwd_dly #(.W(27), .N(S_OUT - S_RHO)) u_dly_rho (
    .clk (clk),
    .en  (en),
    .d   ({rflag_w, rho_w}),
    .q   (rho_d)
  );

  dfwd_dly #(.W(1), .N(S_OUT)) u_dly_last (
    .clk (clk),
    .en  (en),
    .d   (in_r.last_point),
    .q   (last_d)
  );

  dfwd_dly #(.W(120), .N(S_KR)) u_dly_gp (
    .clk (clk),
    .en  (en),
    .d   ({in_r.grad_p_x, in_r.grad_p_y, in_r.grad_p_z}),
    .q   (gp_d)
  );

  // One lane per axis.
  dfwd_lane u_lane_x (
    .clk  (clk),
    .en   (en),
    .b    (b_r),
    .gp   ($signed(gp_d[119:80])),
    .gdir (gdx_r),
    .k    (perm_r),
    .mu   (mu_w),
    .phi  (poro_r),
    .flux (fx_w),
    .vel  (vx_w),
    .flag (lfx_w)
  );

  dfwd_lane u_lane_y (
    .clk  (clk),
    .en   (en),
    .b    (b_r),
    .gp   ($signed(gp_d[79:40])),
    .gdir (gdy_r),
    .k    (perm_r),
    .mu   (mu_w),
    .phi  (poro_r),
    .flux (fy_w),
    .vel  (vy_w),
    .flag (lfy_w)
  );

  dfwd_lane u_lane_z (
    .clk  (clk),
    .en   (en),
    .b    (b_r),
    .gp   ($signed(gp_d[39:0])),
    .gdir (gdz_r),
    .k    (perm_r),
    .mu   (mu_w),
    .phi  (poro_r),
    .flux (fz_w),
    .vel  (vz_w),
    .flag (lfz_w)
  );

  // Result beat from the aligned output registers.
  always_comb begin
    out_data.density        = rho_d[25:0];
    out_data.mobility       = 48'(mob_d);
    out_data.flux_x         = fx_w;
    out_data.flux_y         = fy_w;
    out_data.flux_z         = fz_w;
    out_data.velocity_x     = vx_w;
    out_data.velocity_y     = vy_w;
    out_data.velocity_z     = vz_w;
    out_data.saturated      = rho_d[26] | lfx_w | lfy_w | lfz_w;
    out_data.last_point_out = last_d;
  end

  assign out_valid = vld_r[S_OUT];

endmodule
